// File: design/m3mf_pkg.sv
// Shared types, widths and constants of the median-of-three moving-sum filter.
// Has no dependencies; the cell and the top level import it.
package m3mf_pkg;

	localparam int SAMPLE_W     = 18;
	localparam int TOTAL_W      = 24;
	localparam int COUNT_W      = 7;
	localparam int WINDOW_DEPTH = 64;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W        = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int MED_CELLS    = 2;
	localparam int MIN_COUNT    = 2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(21);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	typedef struct packed {
		logic    vld;
		sample_t data;
	} tap_t;

	function automatic sample_t mid_of_three(sample_t a, sample_t b, sample_t c);
		sample_t lo;
		sample_t hi;
		sample_t res;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			res = lo;
		end else if (c >= hi) begin
			res = hi;
		end else begin
			res = c;
		end
		return res;
	endfunction

endpackage

// File: design/m3mf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module m3mf_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/m3mf_cell.sv
// One tap cell of the median prefilter chain: holds a sample and its valid flag.
// Depends on m3mf_pkg.
module m3mf_cell import m3mf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  tap_t tap_in,
	output tap_t tap_out
);

	logic    vld_q;
	sample_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= tap_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= tap_in.data;
		end
	end

	assign tap_out.vld  = vld_q;
	assign tap_out.data = data_q;

endmodule

// File: design/median3_moving_sum_filter.sv
// Median-of-three prefilter followed by a moving-window sum of pressure samples.
// Each result is registered in stage two, then in the output registers.
// One item per cycle unless out_stall holds results; one window RAM write and read each.
// Reset clears the control state, the window count (to 21) and the per-slot valid flags;
// slots never written since reset read as zero, so the RAM needs no clearing pass.
// Depends on m3mf_pkg, m3mf_cell and m3mf_ram.
module median3_moving_sum_filter import m3mf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [SAMPLE_W-1:0] pressure_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [TOTAL_W-1:0]  pressure_total,
	output logic               window_ready,
	output logic [SAMPLE_W-1:0] filtered_sample
);

	logic [COUNT_W-1:0] count_q;
	slot_t              slot_q;
	logic               full_q;
	logic [WINDOW_DEPTH-1:0] slot_vld_q;

	logic    s2_valid_q;
	sample_t filt_s2;
	logic    full_s2;
	logic    rvld_s2;

	logic    out_valid_q;
	total_t  total_q;
	logic    ready_q;
	sample_t filt_q;

	logic             in_acc;
	logic             s2_adv;
	logic [CMP_W-1:0] cnt_raw;
	logic [CMP_W-1:0] cnt_eff;
	logic [CMP_W-1:0] nxt_ext;
	logic             wrap;
	slot_t            nxt;
	sample_t          filt;
	sample_t          rd_data;
	sample_t          rd_val;
	logic             med_full;

	tap_t taps [MED_CELLS+1];

	assign s2_adv   = s2_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s2_valid_q && !s2_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// Median prefilter: the cells hold the two previous samples, newest first.
	assign taps[0].vld  = 1'b1;
	assign taps[0].data = pressure_sample;

	for (genvar i = 0; i < MED_CELLS; i++) begin : g_tap
		m3mf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (in_acc),
			.tap_in  (taps[i]),
			.tap_out (taps[i+1])
		);
	end

	assign med_full = taps[MED_CELLS].vld;
	assign filt = med_full ? mid_of_three(pressure_sample, taps[1].data, taps[2].data)
	                       : pressure_sample;

	// Slot arithmetic with the count clamped to the usable range.
	always_comb begin
		cnt_raw = CMP_W'(count_q);
		if (cnt_raw < CMP_W'(MIN_COUNT)) begin
			cnt_eff = CMP_W'(MIN_COUNT);
		end else if (cnt_raw > CMP_W'(WINDOW_DEPTH)) begin
			cnt_eff = CMP_W'(WINDOW_DEPTH);
		end else begin
			cnt_eff = cnt_raw;
		end
		nxt_ext = CMP_W'(slot_q) + CMP_W'(1);
		wrap    = (nxt_ext >= cnt_eff);
		nxt     = wrap ? '0 : nxt_ext[SLOT_W-1:0];
	end

	m3mf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (in_acc),
		.waddr (slot_q),
		.wdata (filt),
		.re    (in_acc),
		.raddr (nxt),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			full_q     <= 1'b0;
			slot_vld_q <= '0;
		end else if (in_acc) begin
			slot_q             <= nxt;
			full_q             <= full_q | wrap;
			slot_vld_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (in_acc) begin
			s2_valid_q <= 1'b1;
		end else if (s2_adv) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			filt_s2 <= filt;
			full_s2 <= full_q | wrap;
			rvld_s2 <= slot_vld_q[nxt];
		end
	end

	assign rd_val = rvld_s2 ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (s2_adv) begin
				out_valid_q <= 1'b1;
				total_q     <= total_q + TOTAL_W'(filt_s2) - TOTAL_W'(rd_val);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			ready_q <= full_s2;
			filt_q  <= filt_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign pressure_total  = total_q;
	assign window_ready    = ready_q;
	assign filtered_sample = filt_q;

	// The slot read for subtraction is never the slot being written.
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> nxt != slot_q)
		else $error("window read and write address collide");

	// Once the window has wrapped, the window full flag stays set.
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("window full flag dropped");

	// A stage-two item that cannot move on is still there in the next cycle.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !s2_adv) |=> (s2_valid_q && $stable(filt_s2)))
		else $error("stage-two item lost while stalled");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for median3_moving_sum_filter: a directed table, then random
// phases with bursty input, output stalls and window count changes between phases.
// Depends on m3mf_pkg and the filter RTL; every transfer is checked against a local model or a directed expected value.
module tb_top;
	import m3mf_pkg::*;

	localparam int          IDLE_LIMIT  = 4000;
	localparam int          ITEM_TARGET = 1450;
	localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

	typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;
	typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_STEADY, MIX_HIGH} sample_mix_t;
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} stall_mode_t;

	typedef struct packed {
		total_t  total;
		logic    ready;
		sample_t filt;
	} filter_out_t;

	typedef struct {
		row_kind_t   kind;
		int unsigned value;
		bit          typed;
		filter_out_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	sample_t            pressure_sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	total_t             pressure_total;
	logic               window_ready;
	sample_t            filtered_sample;

	sample_t            med_taps[3];
	int                 med_ptr;
	bit                 med_primed;
	sample_t            win_mem[WINDOW_DEPTH];
	int                 win_ptr;
	bit                 win_wrapped;
	total_t             win_sum;
	logic [COUNT_W-1:0] win_count;

	filter_out_t        due_outputs[$];
	plan_row_t          plan[$];
	int                 items_sent = 0;
	int                 burst_left = 0;
	int                 mismatches = 0;
	stall_mode_t        stall_mode = RX_FREE;
	int                 stall_left = 0;

	median3_moving_sum_filter i_dut (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_valid,
		.in_stall,
		.pressure_sample,
		.out_valid,
		.out_stall,
		.pressure_total,
		.window_ready,
		.filtered_sample
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic filter_out_t step_filter(sample_t s);
		int          span;
		int          cur;
		int          nxt;
		sample_t     lo;
		sample_t     hi;
		sample_t     cap;
		filter_out_t res;
		span = int'(win_count);
		if (span < MIN_COUNT) span = MIN_COUNT;
		if (span > WINDOW_DEPTH) span = WINDOW_DEPTH;
		cur = win_ptr;
		nxt = cur + 1;
		if (nxt >= span) begin
			nxt = 0;
			win_wrapped = 1'b1;
		end
		med_taps[med_ptr] = s;
		if (med_ptr == 2) begin
			med_ptr = 0;
			med_primed = 1'b1;
		end else begin
			med_ptr++;
		end
		lo = (med_taps[0] < med_taps[1]) ? med_taps[0] : med_taps[1];
		hi = (med_taps[0] < med_taps[1]) ? med_taps[1] : med_taps[0];
		cap = (med_taps[2] < hi) ? med_taps[2] : hi;
		res.filt = med_primed ? ((cap > lo) ? cap : lo) : s;
		win_mem[cur] = res.filt;
		win_sum = win_sum + win_mem[cur] - win_mem[nxt];
		win_ptr = nxt;
		res.total = win_sum;
		res.ready = win_wrapped;
		return res;
	endfunction

	function automatic void add_row(row_kind_t kind, int unsigned value, bit typed = 1'b0,
			filter_out_t want = '0);
		plan_row_t row;
		row.kind = kind;
		row.value = value;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	task automatic send_sample(input sample_t s, input bit typed, input filter_out_t typed_out);
		filter_out_t got;
		int          gap;
		in_valid <= 1'b1;
		pressure_sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = step_filter(s);
		due_outputs.push_back(typed ? typed_out : got);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// The count register is only written once every pending result has been taken.
	task automatic write_count(input logic [COUNT_W-1:0] value);
		in_valid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_count = value;
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			RX_FREE: out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin
		filter_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer total %0d ready %0b filtered %0d", $time,
					pressure_total, window_ready, filtered_sample);
			end else begin
				want = due_outputs.pop_front();
				if (pressure_total !== want.total) begin
					mismatches++;
					$display("%0t: pressure_total expected %0d actual %0d", $time, want.total,
						pressure_total);
				end
				if (window_ready !== want.ready) begin
					mismatches++;
					$display("%0t: window_ready expected %0b actual %0b", $time, want.ready,
						window_ready);
				end
				if (filtered_sample !== want.filt) begin
					mismatches++;
					$display("%0t: filtered_sample expected %0d actual %0d", $time, want.filt,
						filtered_sample);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		plan_row_t          row;
		sample_mix_t        mix;
		int                 phase_len;
		int unsigned        base;
		sample_t            s;
		logic [COUNT_W-1:0] cnt;

		win_count = COUNT_RESET;
		for (int i = 0; i < 3; i++) med_taps[i] = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) win_mem[i] = '0;
		med_ptr = 0;
		med_primed = 1'b0;
		win_ptr = 0;
		win_wrapped = 1'b0;
		win_sum = '0;

		// The first two samples pass raw; the third is the first median.
		add_row(ROW_SAMPLE, 0, 1'b1, '{total: 0, ready: 1'b0, filt: 0});
		add_row(ROW_SAMPLE, SAMPLE_MAX, 1'b1,
			'{total: SAMPLE_MAX, ready: 1'b0, filt: SAMPLE_MAX});
		add_row(ROW_SAMPLE, 5, 1'b1, '{total: SAMPLE_MAX + 5, ready: 1'b0, filt: 5});
		add_row(ROW_SAMPLE, SAMPLE_MAX);
		add_row(ROW_SAMPLE, 0);
		add_row(ROW_SAMPLE, 1);
		add_row(ROW_SAMPLE, 'h2AAAA);
		add_row(ROW_SAMPLE, 'h15555);
		// Lowering the count while the slot lies beyond it forces a wrap.
		add_row(ROW_CONFIG, MIN_COUNT);
		add_row(ROW_SAMPLE, SAMPLE_MAX);
		add_row(ROW_SAMPLE, 0);
		add_row(ROW_CONFIG, WINDOW_DEPTH);
		add_row(ROW_SAMPLE, 100000);
		add_row(ROW_SAMPLE, 100001);
		add_row(ROW_SAMPLE, SAMPLE_MAX);
		add_row(ROW_SAMPLE, SAMPLE_MAX);
		add_row(ROW_SAMPLE, 3);
		add_row(ROW_SAMPLE, 7);
		add_row(ROW_CONFIG, 3);
		add_row(ROW_SAMPLE, 50000);
		add_row(ROW_SAMPLE, 0);
		add_row(ROW_CONFIG, (1 << COUNT_W) - 1);
		add_row(ROW_SAMPLE, SAMPLE_MAX);
		add_row(ROW_SAMPLE, 12);
		add_row(ROW_CONFIG, 0);
		add_row(ROW_SAMPLE, 0);
		add_row(ROW_SAMPLE, SAMPLE_MAX);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_CONFIG)
				write_count(COUNT_W'(row.value));
			else
				send_sample(sample_t'(row.value), row.typed, row.want);
		end

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: cnt = '0;
					1: cnt = COUNT_W'(1);
					2: cnt = COUNT_W'(MIN_COUNT);
					3: cnt = COUNT_W'(WINDOW_DEPTH);
					4: cnt = COUNT_W'(WINDOW_DEPTH + 1);
					default: cnt = '1;
				endcase
			end else begin
				cnt = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
			end
			if ($urandom_range(0, 4) != 0) write_count(cnt);
			mix = sample_mix_t'($urandom_range(0, 3));
			base = $urandom_range(0, SAMPLE_MAX - 64);
			phase_len = $urandom_range(20, 160);
			if (phase_len > ITEM_TARGET - items_sent) phase_len = ITEM_TARGET - items_sent;
			repeat (phase_len) begin
				case (mix)
					MIX_UNIFORM: s = sample_t'($urandom);
					MIX_EXTREME: s = ($urandom_range(0, 1) == 0) ? '1 : '0;
					MIX_STEADY: begin
						if ($urandom_range(0, 9) == 0)
							s = sample_t'($urandom);
						else
							s = sample_t'(base + $urandom_range(0, 63));
					end
					default: s = sample_t'(SAMPLE_MAX - $urandom_range(0, 15));
				endcase
				send_sample(s, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_outputs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
